### hdl/focd_pkg.sv
// shared types and constants of the fifo object cache directory
`timescale 1ns / 1ps

package focd_pkg;

  localparam int unsigned SIZE_W        = 21;
  localparam int unsigned KEY_W         = 64;
  localparam int unsigned OUT_SLOT_W    = 5;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 32;

  localparam int unsigned DEF_RING_SLOTS = 32;
  localparam int unsigned DEF_TAG_BITS   = 64;

  localparam logic [SIZE_W-1:0] RESET_BUDGET  = 21'd1049000;
  localparam logic [SIZE_W-1:0] RESET_LARGEST = 21'd102400;

  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_BUDGET    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGEST_OBJECT = 2'd1;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MISS      = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_PRESENT   = 2'd3
  } focd_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_DECIDE,
    S_EVICT,
    S_WRITE
  } focd_state_e;

  typedef struct packed {
    logic              action;
    logic [KEY_W-1:0]  key_tag;
    logic [SIZE_W-1:0] object_bytes;
  } focd_req_t;

  typedef struct packed {
    logic                  hit;
    logic [SIZE_W-1:0]     found_bytes;
    focd_status_e          status;
    logic [OUT_SLOT_W-1:0] slot;
    logic [OUT_SLOT_W-1:0] evictions;
  } focd_rsp_t;

endpackage

### hdl/focd_cell.sv
// one ring slot: stored tag and size, registered match, link in the find chain
`timescale 1ns / 1ps

module focd_cell
  import focd_pkg::*;
#(
  parameter int unsigned TAG_BITS = DEF_TAG_BITS,
  parameter int unsigned SLOT_W   = 5,
  parameter int unsigned SLOT_ID  = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [TAG_BITS-1:0] wr_tag_i,
  input  logic [SIZE_W-1:0]   wr_bytes_i,
  input  logic                cmp_en_i,
  input  logic [TAG_BITS-1:0] key_i,
  input  logic [SLOT_W-1:0]   head_i,
  input  logic [SLOT_W-1:0]   tail_i,
  input  logic                hit_i,
  input  logic [SIZE_W-1:0]   bytes_i,
  input  logic [SLOT_W-1:0]   slot_i,
  output logic                hit_o,
  output logic [SIZE_W-1:0]   bytes_o,
  output logic [SLOT_W-1:0]   slot_o,
  output logic [SIZE_W-1:0]   stored_bytes_o
);

  localparam logic [SLOT_W-1:0] ID = SLOT_W'(SLOT_ID);

  logic [TAG_BITS-1:0] tag_q;
  logic [SIZE_W-1:0]   bytes_q;
  logic                match_q, match_d;
  logic                live;

  // slot lies between oldest entry and next free slot
  always_comb begin
    if (head_i <= tail_i) begin
      live = (ID >= head_i) && (ID < tail_i);
    end else begin
      live = (ID >= head_i) || (ID < tail_i);
    end
  end

  assign match_d = cmp_en_i ? (live && (tag_q == key_i)) : match_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      tag_q   <= wr_tag_i;
      bytes_q <= wr_bytes_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  // live tags are unique, so at most one cell adds to the chain
  assign hit_o          = hit_i | match_q;
  assign bytes_o        = bytes_i | (match_q ? bytes_q : '0);
  assign slot_o         = slot_i | (match_q ? ID : '0);
  assign stored_bytes_o = bytes_q;

endmodule

### hdl/focd_row.sv
// row of ring cells with the find chain and the oldest-entry size read
`timescale 1ns / 1ps

module focd_row
  import focd_pkg::*;
#(
  parameter int unsigned RING_SLOTS = DEF_RING_SLOTS,
  parameter int unsigned TAG_BITS   = DEF_TAG_BITS,
  parameter int unsigned SLOT_W     = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [SLOT_W-1:0]   wr_slot_i,
  input  logic [TAG_BITS-1:0] wr_tag_i,
  input  logic [SIZE_W-1:0]   wr_bytes_i,
  input  logic                cmp_en_i,
  input  logic [TAG_BITS-1:0] key_i,
  input  logic [SLOT_W-1:0]   head_i,
  input  logic [SLOT_W-1:0]   tail_i,
  output logic                hit_o,
  output logic [SIZE_W-1:0]   found_bytes_o,
  output logic [SLOT_W-1:0]   found_slot_o,
  output logic [SIZE_W-1:0]   head_bytes_o
);

  logic                hit_c   [RING_SLOTS+1];
  logic [SIZE_W-1:0]   bytes_c [RING_SLOTS+1];
  logic [SLOT_W-1:0]   slot_c  [RING_SLOTS+1];
  logic [SIZE_W-1:0]   stored  [RING_SLOTS];

  assign hit_c[0]   = 1'b0;
  assign bytes_c[0] = '0;
  assign slot_c[0]  = '0;

  for (genvar g = 0; g < RING_SLOTS; g++) begin : g_cell
    focd_cell #(
      .TAG_BITS (TAG_BITS),
      .SLOT_W   (SLOT_W),
      .SLOT_ID  (g)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .wr_en_i        (wr_en_i && (wr_slot_i == SLOT_W'(g))),
      .wr_tag_i       (wr_tag_i),
      .wr_bytes_i     (wr_bytes_i),
      .cmp_en_i       (cmp_en_i),
      .key_i          (key_i),
      .head_i         (head_i),
      .tail_i         (tail_i),
      .hit_i          (hit_c[g]),
      .bytes_i        (bytes_c[g]),
      .slot_i         (slot_c[g]),
      .hit_o          (hit_c[g+1]),
      .bytes_o        (bytes_c[g+1]),
      .slot_o         (slot_c[g+1]),
      .stored_bytes_o (stored[g])
    );
  end

  assign hit_o         = hit_c[RING_SLOTS];
  assign found_bytes_o = bytes_c[RING_SLOTS];
  assign found_slot_o  = slot_c[RING_SLOTS];
  assign head_bytes_o  = stored[head_i];

endmodule

### hdl/fifo_object_cache_directory.sv
// top level of the fifo object cache directory: control sequencer and registers
`timescale 1ns / 1ps

//  channel   ports                                   beat taken when
//  request   start_i, busy_o, req_i                  start_i & ~busy_o
//  result    rsp_valid_o, rsp_o                      rsp_valid_o (one cycle, no stall)
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i,  cfg_valid_i & cfg_ready_o
//            cfg_data_i
//
//  lookups, hits and rejected inserts: the request passes S_CMP and S_DECIDE;
//    the strobe is registered in S_DECIDE and a new request beat can be taken with it
//  successful insert: b budget evictions, one per cycle through the head read,
//    then S_WRITE; the extra full-ring eviction shares the last evict cycle
//  the slot compare is registered in all cells, then read through the find chain
//  reset empties the ring and loads the default budget and size limit
//  config is always ready; write it only while busy_o is low
//  the result port has no stall: a beat is gone after its one strobe cycle

module fifo_object_cache_directory
  import focd_pkg::*;
#(
  parameter int unsigned RING_SLOTS = DEF_RING_SLOTS,
  parameter int unsigned TAG_BITS   = DEF_TAG_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  focd_req_t             req_i,
  output logic                  rsp_valid_o,
  output focd_rsp_t             rsp_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned SLOT_W = $clog2(RING_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_SLOTS - 1);

  focd_state_e state_q, state_d;

  logic                act_q, act_d;
  logic [TAG_BITS-1:0] key_q, key_d;
  logic [SIZE_W-1:0]   size_q, size_d;
  logic [SLOT_W-1:0]   head_q, head_d;
  logic [SLOT_W-1:0]   tail_q, tail_d;
  logic [SIZE_W-1:0]   used_q, used_d;
  logic [SIZE_W-1:0]   budget_q, budget_d;
  logic [SIZE_W-1:0]   largest_q, largest_d;
  logic [SLOT_W-1:0]   evict_q, evict_d;
  logic                rsp_valid_q, rsp_valid_d;
  focd_rsp_t           rsp_q, rsp_d;

  logic                accept;
  logic                row_hit;
  logic [SIZE_W-1:0]   row_bytes;
  logic [SLOT_W-1:0]   row_slot;
  logic [SIZE_W-1:0]   head_bytes;
  logic [SLOT_W-1:0]   head_next;
  logic [SLOT_W-1:0]   tail_next;
  logic                ring_empty;
  logic                ring_full;
  logic                over_budget;
  logic                too_large;
  logic [SIZE_W-1:0]   used_after_drop;
  logic                wr_en;
  logic [SLOT_W+OUT_SLOT_W-1:0] slot_ext;
  logic [SLOT_W+OUT_SLOT_W-1:0] tail_ext;
  logic [SLOT_W+OUT_SLOT_W-1:0] evict_ext;

  assign accept      = start_i && (state_q == S_IDLE);
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // ring bookkeeping
  assign head_next   = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
  assign tail_next   = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
  assign ring_empty  = (head_q == tail_q);
  assign ring_full   = (tail_next == head_q);
  assign over_budget = ({1'b0, used_q} + {1'b0, size_q}) > {1'b0, budget_q};
  assign too_large   = (size_q > largest_q) || (size_q > budget_q);
  assign used_after_drop = (head_bytes > used_q) ? '0 : used_q - head_bytes;
  assign wr_en       = (state_q == S_WRITE);

  // fit slot numbers to the 5-bit result fields
  assign slot_ext  = {{OUT_SLOT_W{1'b0}}, row_slot};
  assign tail_ext  = {{OUT_SLOT_W{1'b0}}, tail_q};
  assign evict_ext = {{OUT_SLOT_W{1'b0}}, evict_q};

  focd_row #(
    .RING_SLOTS (RING_SLOTS),
    .TAG_BITS   (TAG_BITS),
    .SLOT_W     (SLOT_W)
  ) u_row (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_en_i       (wr_en),
    .wr_slot_i     (tail_q),
    .wr_tag_i      (key_q),
    .wr_bytes_i    (size_q),
    .cmp_en_i      (state_q == S_CMP),
    .key_i         (key_q),
    .head_i        (head_q),
    .tail_i        (tail_q),
    .hit_o         (row_hit),
    .found_bytes_o (row_bytes),
    .found_slot_o  (row_slot),
    .head_bytes_o  (head_bytes)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (row_hit || (act_q == ACT_LOOKUP) || too_large) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_EVICT;
        end
      end
      S_EVICT: begin
        // keep dropping while over budget; a full ring costs one more drop
        if (!(!ring_empty && over_budget)) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // datapath and result registers
  always_comb begin
    act_d       = act_q;
    key_d       = key_q;
    size_d      = size_q;
    head_d      = head_q;
    tail_d      = tail_q;
    used_d      = used_q;
    budget_d    = budget_q;
    largest_d   = largest_q;
    evict_d     = evict_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BYTE_BUDGET:    budget_d  = cfg_data_i[SIZE_W-1:0];
        CFG_LARGEST_OBJECT: largest_d = cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          act_d   = req_i.action;
          key_d   = req_i.key_tag[TAG_BITS-1:0];
          size_d  = req_i.object_bytes;
          evict_d = '0;
        end
      end
      S_CMP: ;
      S_DECIDE: begin
        rsp_d.hit         = 1'b0;
        rsp_d.found_bytes = '0;
        rsp_d.slot        = '0;
        rsp_d.evictions   = '0;
        priority if (row_hit) begin
          rsp_valid_d       = 1'b1;
          rsp_d.hit         = 1'b1;
          rsp_d.found_bytes = row_bytes;
          rsp_d.slot        = slot_ext[OUT_SLOT_W-1:0];
          rsp_d.status      = (act_q == ACT_LOOKUP) ? ST_OK : ST_PRESENT;
        end else if (act_q == ACT_LOOKUP) begin
          rsp_valid_d  = 1'b1;
          rsp_d.status = ST_MISS;
        end else if (too_large) begin
          rsp_valid_d  = 1'b1;
          rsp_d.status = ST_TOO_LARGE;
        end else begin
          rsp_d.status = ST_OK;
        end
      end
      S_EVICT: begin
        if ((!ring_empty && over_budget) || ring_full) begin
          used_d  = used_after_drop;
          head_d  = head_next;
          evict_d = evict_q + 1'b1;
        end
      end
      S_WRITE: begin
        used_d            = used_q + size_q;
        tail_d            = tail_next;
        rsp_valid_d       = 1'b1;
        rsp_d.hit         = 1'b0;
        rsp_d.found_bytes = '0;
        rsp_d.status      = ST_OK;
        rsp_d.slot        = tail_ext[OUT_SLOT_W-1:0];
        rsp_d.evictions   = evict_ext[OUT_SLOT_W-1:0];
      end
      default: ;
    endcase
  end

  // payload holding registers
  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    key_q  <= key_d;
    size_q <= size_d;
    rsp_q  <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      used_q      <= '0;
      budget_q    <= RESET_BUDGET;
      largest_q   <= RESET_LARGEST;
      evict_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      used_q      <= used_d;
      budget_q    <= budget_d;
      largest_q   <= largest_d;
      evict_q     <= evict_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
